FILE: hw/rtl/plsc_pkg.sv
// Shared types, character codes and token helpers for the port-list syntax checker.
package plsc_pkg;

    // Character code units
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_DASH  = 16'h002D;
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [15:0] CH_NINE  = 16'h0039;

    // Port limits; the accumulator clamps at PART_SAT
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned PART_W   = PORT_W + 1;
    localparam int unsigned ACC_W    = PART_W + 4;
    localparam logic [PART_W-1:0] PORT_MAX = 17'd65535;
    localparam logic [PART_W-1:0] PART_SAT = 17'd65536;

    // Parse state carried from one character to the next
    typedef struct packed {
        logic [PART_W-1:0] part_value;
        logic              part_has_digit;
        logic              in_range_upper;
        logic [PORT_W-1:0] range_low;
        logic              failed;
    } tok_state_t;

    localparam tok_state_t TOK_STATE_RST = '{
        part_value:     '0,
        part_has_digit: 1'b0,
        in_range_upper: 1'b0,
        range_low:      '0,
        failed:         1'b0
    };

    // The current digit run is a legal port number
    function automatic logic run_is_port(input tok_state_t st);
        return st.part_has_digit && (st.part_value != '0) && (st.part_value <= PORT_MAX);
    endfunction

    // Close the current token: judge it and clear the token fields
    function automatic tok_state_t close_token(input tok_state_t st);
        tok_state_t res;
        res = TOK_STATE_RST;
        res.failed = st.failed || !run_is_port(st)
                   || (st.in_range_upper && ({1'b0, st.range_low} > st.part_value));
        return res;
    endfunction

endpackage

FILE: hw/rtl/port_list_syntax_checker.sv
// Top level of the port-list syntax checker: input register, parse logic, result register.
//
//  channel | signals                                | direction | role
//  --------+----------------------------------------+-----------+------------------------------
//  in      | in_valid, in_stall, char_code,          | input     | one character item per accept
//          | has_char, last                          |           |
//  out     | out_valid, out_stall, valid_res         | output    | one verdict per last item
//
// One item per cycle unless a last item waits on a stalled result, a rate set by the single
// parse stage between the input and result registers; the verdict loads with the last item.
// Reset (rst_n low, asynchronous) empties both registers and clears the parse state.
// A stalled result holds the result register; further non-last items keep flowing, and a
// last item waits in the input register, which then stalls the input channel.
module port_list_syntax_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] char_code,
    input  logic        has_char,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res
);

    // Input register
    logic        in_valid_reg;
    logic [15:0] char_reg;
    logic        has_char_reg;
    logic        last_reg;

    // Parse state
    plsc_pkg::tok_state_t st_reg;
    plsc_pkg::tok_state_t st_next;
    plsc_pkg::tok_state_t st_char;
    plsc_pkg::tok_state_t st_end;

    // Result register
    logic out_valid_reg;
    logic valid_res_reg;
    logic valid_res_next;

    logic out_free;
    logic advance;
    logic load_res;
    logic in_take;

    logic                          is_digit;
    logic [3:0]                    digit;
    logic [plsc_pkg::ACC_W-1:0]    acc_sum;

    // Handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign load_res = advance && last_reg;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Character decode and decimal accumulate
    assign is_digit = (char_reg >= plsc_pkg::CH_ZERO) && (char_reg <= plsc_pkg::CH_NINE);
    assign digit    = 4'(char_reg - plsc_pkg::CH_ZERO);
    assign acc_sum  = ({4'd0, st_reg.part_value} << 3) + ({4'd0, st_reg.part_value} << 1)
                    + plsc_pkg::ACC_W'(digit);

    // Apply one character to the parse state
    always_comb
    begin
        st_char = st_reg;
        if (has_char_reg)
        begin
            if (char_reg == plsc_pkg::CH_COMMA)
            begin
                st_char = plsc_pkg::close_token(st_reg);
            end
            else if (char_reg == plsc_pkg::CH_DASH)
            begin
                st_char.failed = st_reg.failed || st_reg.in_range_upper
                               || !plsc_pkg::run_is_port(st_reg);
                st_char.range_low      = st_reg.part_value[plsc_pkg::PORT_W-1:0];
                st_char.in_range_upper = 1'b1;
                st_char.part_value     = '0;
                st_char.part_has_digit = 1'b0;
            end
            else if (is_digit)
            begin
                st_char.part_value = (acc_sum > plsc_pkg::ACC_W'(plsc_pkg::PART_SAT))
                                   ? plsc_pkg::PART_SAT
                                   : acc_sum[plsc_pkg::PART_W-1:0];
                st_char.part_has_digit = 1'b1;
            end
            else
            begin
                st_char.failed = 1'b1;
            end
        end
    end

    // End of string: judge the final token, then start over
    always_comb
    begin
        st_next        = st_char;
        st_end         = plsc_pkg::close_token(st_char);
        valid_res_next = !st_end.failed;
        if (last_reg)
        begin
            st_next = plsc_pkg::TOK_STATE_RST;
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= plsc_pkg::TOK_STATE_RST;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                st_reg <= st_next;
            end

            if (load_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg     <= char_code;
            has_char_reg <= has_char;
            last_reg     <= last;
        end
        if (load_res)
        begin
            valid_res_reg <= valid_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;

`ifndef SYNTHESIS
    // A new verdict only follows a processed last item
    a_res_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(load_res))
        else $error("verdict without a last item");

    // Parse state is clean after each verdict
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (st_reg == plsc_pkg::TOK_STATE_RST))
        else $error("parse state not cleared after verdict");

    // Accumulator never passes its clamp value
    a_part_sat: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.part_value <= plsc_pkg::PART_SAT)
        else $error("digit accumulator above clamp");

    // Input stalls only behind a held last item and a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && last_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the port-list syntax checker: stimulus, predictor and checks.
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam int IDLE_PERCENT   = 8;

    typedef struct {
        bit [15:0] code;
        bit        has_char;
        bit        last;
    } char_item_t;

    // DUT ports; inputs start at known values
    logic        clk;
    logic        rst_n;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [15:0] char_code = '0;
    logic        has_char  = 1'b0;
    logic        last      = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        valid_res;

    // Items waiting to be offered, and verdicts still owed by the DUT
    char_item_t char_items[$];
    bit         verdicts_due[$];

    bit item_taken = 1'b0;
    bit no_idle    = 1'b0;
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    int errors        = 0;
    int verdicts_seen = 0;
    int valid_lists   = 0;
    int chars_taken   = 0;

    // Predictor state for the string being parsed
    bit [16:0] run_value     = '0;
    bit        run_has_digit = 1'b0;
    bit        after_dash    = 1'b0;
    bit [15:0] pair_low      = '0;
    bit        list_bad      = 1'b0;

    port_list_syntax_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .has_char  (has_char),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .valid_res (valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    //--------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------
    function automatic bit digit_run_is_port();
        return run_has_digit && run_value >= 1 && run_value <= 17'd65535;
    endfunction

    task automatic close_list_token();
        if (!digit_run_is_port())
            list_bad = 1'b1;
        else if (after_dash && pair_low > run_value)
            list_bad = 1'b1;
        run_value     = '0;
        run_has_digit = 1'b0;
        after_dash    = 1'b0;
        pair_low      = '0;
    endtask

    task automatic take_list_char(input bit [15:0] c);
        int unsigned grown;
        if (c == plsc_pkg::CH_COMMA)
        begin
            close_list_token();
        end
        else if (c == plsc_pkg::CH_DASH)
        begin
            // second dash or missing low port
            if (after_dash || !digit_run_is_port())
                list_bad = 1'b1;
            pair_low      = run_value[15:0];
            after_dash    = 1'b1;
            run_value     = '0;
            run_has_digit = 1'b0;
        end
        else if (c >= plsc_pkg::CH_ZERO && c <= plsc_pkg::CH_NINE)
        begin
            // accumulate, clamping just above the port range
            grown = 32'(run_value) * 10 + 32'(c - plsc_pkg::CH_ZERO);
            run_value     = (grown > plsc_pkg::PART_SAT) ? plsc_pkg::PART_SAT : grown[16:0];
            run_has_digit = 1'b1;
        end
        else
        begin
            list_bad = 1'b1;
        end
    endtask

    task automatic predict_item(input bit [15:0] c, input bit hc, input bit lst);
        if (hc)
            take_list_char(c);
        if (lst)
        begin
            close_list_token();
            verdicts_due.push_back(!list_bad);
            list_bad = 1'b0;
        end
    endtask

    //--------------------------------------------------------------------
    // Random idling, suppressed during the quiet stretch
    //--------------------------------------------------------------------
    function automatic bit take_break();
        return !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    //--------------------------------------------------------------------
    // Sampling at the rising edge: results first, then input accepts
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && out_valid && !out_stall)
        begin
            verdicts_seen++;
            if (valid_res)
                valid_lists++;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected verdict valid_res=%0b, none expected",
                         $time, valid_res);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (valid_res !== want)
                begin
                    errors++;
                    $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                             $time, want, valid_res);
                end
            end
        end
        item_taken = rst_n && in_valid && !in_stall;
        if (item_taken)
        begin
            predict_item(char_code, has_char, last);
            if (has_char)
                chars_taken++;
            void'(char_items.pop_front());
        end
    end

    // Sender: holds a stalled item, otherwise offers the next one
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !item_taken)
        begin
            in_valid <= 1'b1;
        end
        else if (char_items.size() > 0 && !take_break())
        begin
            in_valid  <= 1'b1;
            char_code <= char_items[0].code;
            has_char  <= char_items[0].has_char;
            last      <= char_items[0].last;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= take_break();
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    //--------------------------------------------------------------------
    // Stimulus builders
    //--------------------------------------------------------------------
    task automatic add_item(input bit [15:0] c, input bit hc, input bit lst);
        char_item_t it;
        it.code     = c;
        it.has_char = hc;
        it.last     = lst;
        char_items.push_back(it);
    endtask

    // Dashes, commas, digits, codes just outside the digits, or any 16-bit code at all
    function automatic bit [15:0] noise_char();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 16'($urandom());
        else if (r == 3)
            return ($urandom_range(0, 1) == 0) ? plsc_pkg::CH_ZERO - 16'd1
                                               : plsc_pkg::CH_NINE + 16'd1;
        else if (r < 6)
            return plsc_pkg::CH_DASH;
        else if (r < 8)
            return plsc_pkg::CH_COMMA;
        else
            return plsc_pkg::CH_ZERO + 16'($urandom_range(0, 9));
    endfunction

    // Port values weighted toward the edges of the legal range
    function automatic int unsigned pick_port();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 999);
        else if (r < 72)
            return $urandom_range(1000, 65535);
        else if (r < 80)
            return 65535;
        else if (r < 86)
            return 1;
        else if (r < 91)
            return 0;
        else if (r < 96)
            return $urandom_range(65536, 99999);
        else
            return $urandom();
    endfunction

    // Decimal digits of v, sometimes with leading zeros
    task automatic put_number(ref bit [15:0] text[$], input int unsigned v);
        bit [15:0]   digs[$];
        int unsigned r;
        r = v;
        do
        begin
            digs.push_front(plsc_pkg::CH_ZERO + 16'(r % 10));
            r = r / 10;
        end
        while (r != 0);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) digs.push_front(plsc_pkg::CH_ZERO);
        text = {text, digs};
    endtask

    // Break an otherwise well-formed list in one place
    task automatic corrupt(ref bit [15:0] text[$]);
        int unsigned pos;
        pos = $urandom_range(0, text.size());
        case ($urandom_range(0, 5))
            0: text.insert(pos, noise_char());
            1: text.insert(pos, plsc_pkg::CH_DASH);
            2: text.insert(pos, plsc_pkg::CH_COMMA);
            3: text.push_back(plsc_pkg::CH_COMMA);
            4: if (text.size() > 0) text.delete($urandom_range(0, text.size() - 1));
            default: text.push_front(plsc_pkg::CH_COMMA);
        endcase
    endtask

    // Send a string, with stray empty items and sometimes an empty closing item
    task automatic emit_string(input bit [15:0] text[$], ref int pushed);
        bit end_blank;
        end_blank = (text.size() == 0) || ($urandom_range(0, 99) < 8);
        foreach (text[i])
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                add_item(16'($urandom()), 1'b0, 1'b0);
                pushed++;
            end
            add_item(text[i], 1'b1, !end_blank && (i == text.size() - 1));
            pushed++;
        end
        if (end_blank)
        begin
            add_item(16'($urandom()), 1'b0, 1'b1);
            pushed++;
        end
    endtask

    task automatic push_random_list(ref int pushed);
        bit [15:0]   text[$];
        int unsigned style;
        int unsigned lo;
        int unsigned hi;
        int unsigned tmp;
        style = $urandom_range(0, 99);
        if (style < 12)
        begin
            repeat ($urandom_range(0, 6)) text.push_back(noise_char());
        end
        else
        begin
            for (int t = 0; t < int'($urandom_range(1, 4)); t++)
            begin
                if (t > 0)
                    text.push_back(plsc_pkg::CH_COMMA);
                if ($urandom_range(0, 2) == 0)
                begin
                    lo = pick_port();
                    hi = pick_port();
                    // mostly ordered pairs, some reversed
                    if ($urandom_range(0, 3) != 0 && lo > hi)
                    begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    put_number(text, lo);
                    text.push_back(plsc_pkg::CH_DASH);
                    put_number(text, hi);
                end
                else
                begin
                    put_number(text, pick_port());
                end
            end
            if (style >= 80)
                corrupt(text);
        end
        emit_string(text, pushed);
    endtask

    task automatic random_batch(input int count);
        int pushed;
        pushed = 0;
        while (pushed < count)
            push_random_list(pushed);
    endtask

    task automatic push_directed();
        // empty string
        add_item(16'h0000, 1'b0, 1'b1);
        // pair and port, with a stray empty item inside
        add_item(plsc_pkg::CH_ZERO + 16'd1, 1'b1, 1'b0);
        add_item(plsc_pkg::CH_DASH, 1'b1, 1'b0);
        add_item(plsc_pkg::CH_ZERO + 16'd2, 1'b1, 1'b0);
        add_item(16'hFFFF, 1'b0, 1'b0);
        add_item(plsc_pkg::CH_COMMA, 1'b1, 1'b0);
        add_item(plsc_pkg::CH_ZERO + 16'd7, 1'b1, 1'b1);
        // 70000: above the port range
        add_item(plsc_pkg::CH_ZERO + 16'd7, 1'b1, 1'b0);
        repeat (4) add_item(plsc_pkg::CH_ZERO, 1'b1, 1'b0);
        add_item(plsc_pkg::CH_ZERO, 1'b0, 1'b1);
        // reversed pair 3-1
        add_item(plsc_pkg::CH_ZERO + 16'd3, 1'b1, 1'b0);
        add_item(plsc_pkg::CH_DASH, 1'b1, 1'b0);
        add_item(plsc_pkg::CH_ZERO + 16'd1, 1'b1, 1'b1);
        // single illegal character, top code
        add_item(16'hFFFF, 1'b1, 1'b1);
        // trailing comma, closed by an empty item
        add_item(plsc_pkg::CH_NINE, 1'b1, 1'b0);
        add_item(plsc_pkg::CH_COMMA, 1'b1, 1'b0);
        add_item(16'h0000, 1'b0, 1'b1);
        // port zero
        add_item(plsc_pkg::CH_ZERO, 1'b1, 1'b1);
        // NUL character
        add_item(16'h0000, 1'b1, 1'b1);
    endtask

    task automatic wait_drain();
        while (char_items.size() != 0 || verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    //--------------------------------------------------------------------
    // Test sequence
    //--------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_directed();
        random_batch(500);
        // sender pause: let every verdict come back
        wait_drain();

        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        random_batch(350);
        wait_drain();

        // stretch with no idling on either side
        no_idle = 1'b1;
        random_batch(450);
        wait_drain();
        no_idle = 1'b0;

        random_batch(400);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Judged %0d port lists (%0d well formed) from %0d characters,",
                 verdicts_seen, valid_lists, chars_taken);
        $display("including a long output hold-off and a stretch with no idling.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/plsc_pkg.sv
hw/rtl/port_list_syntax_checker.sv
sim/tb_top.sv
